>>> rtl/core/ule_pkg.sv
// Shared types and codes for the unordered list engine.
`timescale 1ns / 1ps

package ule_pkg;

    localparam int DATA_W = 32;

    typedef logic signed [DATA_W-1:0] t_data;

    // request modes
    localparam logic [2:0] MODE_APPEND     = 3'd0;
    localparam logic [2:0] MODE_REMOVE     = 3'd1;
    localparam logic [2:0] MODE_SEARCH     = 3'd2;
    localparam logic [2:0] MODE_READ_INDEX = 3'd3;
    localparam logic [2:0] MODE_CLEAR      = 3'd4;
    localparam logic [2:0] MODE_FIRST      = 3'd5;
    localparam logic [2:0] MODE_LAST       = 3'd6;
    localparam logic [2:0] MODE_READ_NEXT  = 3'd7;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_BAD_INDEX = 2'd3;

    localparam t_data FAIL_DATA = '1;

endpackage

>>> rtl/core/unordered_list_engine.sv
// Unordered list engine: fixed-capacity list of signed values in one memory.
//
// A request is taken when i_start is high and o_busy is low; its single result
// appears for one cycle with o_done high and cannot be held off. Append, clear
// and both cursor moves answer in the cycle after the request is taken. Read
// index and read next pass through the read state because of the memory's
// registered read, or answer straight from idle when the index or cursor is
// out of range. Search and remove walk the entries through the single read
// port, one entry a cycle: search stops at the first match, remove always
// walks to the last entry because it moves every later entry down one place
// as it goes, using the write port behind the read. A request on an empty list
// never enters the read or scan state. No clearing pass is needed after reset.
`timescale 1ns / 1ps

module unordered_list_engine #(
    parameter int CAPACITY = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [2:0]           i_mode,
    input  ule_pkg::t_data       i_item_value,
    input  logic [15:0]          i_read_index,
    output logic                 o_done,
    output logic [1:0]           o_status,
    output ule_pkg::t_data       o_data_out,
    output logic                 o_found,
    output logic [5:0]           o_position,
    output logic [6:0]           o_count,
    output logic                 o_empty_flag,
    output logic                 o_full_flag
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    localparam logic [CW-1:0] CNT_MAX = CW'(CAPACITY);
    localparam logic [CW-1:0] CNT_ONE = CW'(1);
    localparam logic [AW-1:0] ADR_ONE = AW'(1);

    logic [1:0]      r_state,  n_state;
    logic [CW-1:0]   r_count,  n_count;
    logic [CW-1:0]   r_cursor, n_cursor;
    logic [AW-1:0]   r_chk,    n_chk;
    logic            r_done,   n_done;
    logic [2:0]      r_mode,   n_mode;
    ule_pkg::t_data  r_value,  n_value;
    logic [1:0]      r_status, n_status;
    ule_pkg::t_data  r_data,   n_data;
    logic            r_found,  n_found;
    logic [AW-1:0]   r_pos,    n_pos;

    logic            w_we;
    logic [AW-1:0]   w_waddr;
    ule_pkg::t_data  w_wdata;
    logic            w_re;
    logic [AW-1:0]   w_raddr;
    ule_pkg::t_data  w_rdata;

    logic            w_idx_ok;
    logic            w_cur_ok;
    logic [CW-1:0]   w_cnt_m1;
    logic            w_last;
    logic            w_hit;
    logic            w_stop;
    logic [CW+6:0]   w_cnt_ext;
    logic [AW+5:0]   w_pos_ext;

    ule_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_idx_ok = i_read_index < 16'(r_count);
    assign w_cur_ok = r_cursor < r_count;
    assign w_cnt_m1 = r_count - CNT_ONE;
    assign w_last   = (r_chk == w_cnt_m1[AW-1:0]);
    assign w_hit    = (w_rdata == r_value);
    assign w_stop   = w_last || (!r_found && w_hit && (r_mode == ule_pkg::MODE_SEARCH));

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_cursor = r_cursor;
        n_chk    = r_chk;
        n_done   = 1'b0;
        n_mode   = r_mode;
        n_value  = r_value;
        n_status = r_status;
        n_data   = r_data;
        n_found  = r_found;
        n_pos    = r_pos;
        w_we     = 1'b0;
        w_waddr  = r_count[AW-1:0];
        w_wdata  = i_item_value;
        w_re     = 1'b0;
        w_raddr  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_mode   = i_mode;
                    n_value  = i_item_value;
                    n_status = ule_pkg::ST_OK;
                    n_data   = '0;
                    n_found  = 1'b0;
                    n_pos    = '0;
                    unique case (i_mode)
                        ule_pkg::MODE_APPEND: begin
                            n_done = 1'b1;
                            if (r_count == CNT_MAX) begin
                                n_status = ule_pkg::ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                n_count = r_count + CNT_ONE;
                            end
                        end
                        ule_pkg::MODE_REMOVE, ule_pkg::MODE_SEARCH: begin
                            if (r_count == '0) begin
                                n_done   = 1'b1;
                                n_status = ule_pkg::ST_NOT_FOUND;
                            end else begin
                                w_re    = 1'b1;
                                n_chk   = '0;
                                n_state = S_SCAN;
                            end
                        end
                        ule_pkg::MODE_READ_INDEX: begin
                            if (w_idx_ok) begin
                                w_re    = 1'b1;
                                w_raddr = i_read_index[AW-1:0];
                                n_state = S_READ;
                            end else begin
                                n_done   = 1'b1;
                                n_status = ule_pkg::ST_BAD_INDEX;
                                n_data   = ule_pkg::FAIL_DATA;
                            end
                        end
                        ule_pkg::MODE_CLEAR: begin
                            n_done  = 1'b1;
                            n_count = '0;
                        end
                        ule_pkg::MODE_FIRST: begin
                            n_done   = 1'b1;
                            n_cursor = '0;
                        end
                        ule_pkg::MODE_LAST: begin
                            n_done   = 1'b1;
                            n_cursor = (r_count == '0) ? '0 : w_cnt_m1;
                        end
                        ule_pkg::MODE_READ_NEXT: begin
                            if (w_cur_ok) begin
                                w_re     = 1'b1;
                                w_raddr  = r_cursor[AW-1:0];
                                n_cursor = r_cursor + CNT_ONE;
                                n_state  = S_READ;
                            end else begin
                                n_done   = 1'b1;
                                n_status = ule_pkg::ST_BAD_INDEX;
                                n_data   = ule_pkg::FAIL_DATA;
                            end
                        end
                    endcase
                end
            end
            S_READ: begin
                n_data  = w_rdata;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_SCAN: begin
                // first match records the position; after it, move entries down
                if (!r_found && w_hit) begin
                    n_found = 1'b1;
                    n_pos   = r_chk;
                end else if (r_found) begin
                    w_we    = 1'b1;
                    w_waddr = r_chk - ADR_ONE;
                    w_wdata = w_rdata;
                end
                if (w_stop) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                    if (!(r_found || w_hit)) begin
                        n_status = ule_pkg::ST_NOT_FOUND;
                    end else if (r_mode == ule_pkg::MODE_REMOVE) begin
                        n_count = w_cnt_m1;
                    end
                end else begin
                    w_re    = 1'b1;
                    w_raddr = r_chk + ADR_ONE;
                    n_chk   = r_chk + ADR_ONE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_cursor <= '0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_cursor <= n_cursor;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk    <= n_chk;
        r_mode   <= n_mode;
        r_value  <= n_value;
        r_status <= n_status;
        r_data   <= n_data;
        r_found  <= n_found;
        r_pos    <= n_pos;
    end

    assign w_cnt_ext = {7'd0, r_count};
    assign w_pos_ext = {6'd0, r_pos};

    assign o_busy       = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_status     = r_status;
    assign o_data_out   = r_data;
    assign o_found      = r_found;
    assign o_position   = w_pos_ext[5:0];
    assign o_count      = w_cnt_ext[6:0];
    assign o_empty_flag = (r_count == '0);
    assign o_full_flag  = (r_count == CNT_MAX);

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy)
        else $error("result strobe while still busy");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("entry count above capacity");

    a_read_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> o_done)
        else $error("read did not finish in one cycle");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CW'(r_chk) < r_count))
        else $error("scan address beyond entry count");

endmodule

>>> rtl/core/ule_ram.sv
// Entry store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module ule_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [AW-1:0]         i_waddr,
    input  ule_pkg::t_data        i_wdata,
    input  logic                  i_re,
    input  logic [AW-1:0]         i_raddr,
    output ule_pkg::t_data        o_rdata
);

    ule_pkg::t_data r_mem [DEPTH];
    ule_pkg::t_data r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
